// ===== rtl/core/gls_pkg.sv =====
package gls_pkg;

    // default line store depth
    localparam int MAX_WIDTH_DEF = 1024;

    // word field widths
    localparam int SAMPLE_W = 16;
    localparam int LAP_W    = 32;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 10;

    // configuration register widths
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_INV_W    = 32;

    // reset values of the configuration registers
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RST  = 11'd64;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RST = 16'd64;
    localparam logic [CFG_INV_W-1:0]    INV_RST    = 32'd65536;

    // smallest grid extent in either direction
    localparam int MIN_DIM = 2;

    // stencil sum: at most 4 neighbours plus 4x centre of Q2.14 values
    localparam int SUM_W  = 19;
    localparam int PROD_W = SUM_W + CFG_INV_W + 1;
    localparam int FRAC_W = 16;
    localparam int Q_W    = PROD_W - FRAC_W;

    localparam logic signed [LAP_W-1:0] LAP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [LAP_W-1:0] LAP_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_INV    = 2'd2
    } t_cfg_idx;

    // neighbour availability of a word held in the read stage
    typedef struct packed {
        logic has_up;    // row >= 1: point one row up is emitted
        logic left_ok;   // col > 0
        logic right_ok;  // col < last column
        logic up_ok;     // row >= 2
        logic last_row;
        logic left2;     // col >= 2
        logic corner;    // col is the last column
    } t_s1_ctl;

    // bypass of the write made on the edge the word's reads were issued
    typedef struct packed {
        logic ra_c;
        logic ra_r;
        logic rt_c;
        logic rt_l;
    } t_fwd;

endpackage

// ===== rtl/core/grid_laplacian_stencil.sv =====
// Streaming five-point Laplacian over a raster-ordered grid frame.
//
// Input channel: i_in_valid / o_in_stall carry one Q2.14 sample word per
// accepted edge, row by row, column by column. Output channel: o_out_valid /
// i_out_stall carry result words: scaled Laplacian, row, column, last word of
// the input word's run, and end of frame. Config is a plain write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write it only while the
// block is idle, and the block itself does not enforce this.
//
// Throughput: one sample per cycle unless o_in_stall is raised. Rows 1 .. h-2
// give one result per sample, row 0 none; the last row gives one on its first
// column, two on the columns after it and three on its last column, so there
// the single output multiplier sets the rate and the input is stalled.
// Path: a result passes the read stage and the pending-result stage and is
// registered in the output register that drives o_out_valid.
//
// Reset (synchronous, active low) restores the register defaults, clears
// the counters, the previous-sample pair and all valid flags. The line
// stores are not cleared; no clearing pass is run.
// A stall at the output holds the output word; the pending-result stage and
// then the read stage fill up behind it before o_in_stall rises.
module grid_laplacian_stencil #(
    parameter int MAX_WIDTH = gls_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [gls_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [gls_pkg::LAP_W-1:0]    o_laplacian,
    output logic [gls_pkg::ROW_W-1:0]           o_out_row,
    output logic [gls_pkg::COL_W-1:0]           o_out_col,
    output logic                                o_last_of_run,
    output logic                                o_end_of_frame,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [gls_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gls_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW_MIN = gls_pkg::CFG_WIDTH_W;
    localparam int CW = (CW_MIN > $clog2(MAX_WIDTH + 1)) ? CW_MIN : $clog2(MAX_WIDTH + 1);
    localparam int SW = gls_pkg::SAMPLE_W;
    localparam int UW = gls_pkg::SUM_W;
    localparam int RW = gls_pkg::ROW_W;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [gls_pkg::CFG_WIDTH_W-1:0]  r_cfg_width;
    logic [gls_pkg::CFG_HEIGHT_W-1:0] r_cfg_height;
    logic [gls_pkg::CFG_INV_W-1:0]    r_cfg_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= gls_pkg::WIDTH_RST;
            r_cfg_height <= gls_pkg::HEIGHT_RST;
            r_cfg_inv    <= gls_pkg::INV_RST;
        end else if (i_cfg_we) begin
            case (gls_pkg::t_cfg_idx'(i_cfg_idx))
                gls_pkg::CFG_WIDTH:  r_cfg_width  <= i_cfg_data[gls_pkg::CFG_WIDTH_W-1:0];
                gls_pkg::CFG_HEIGHT: r_cfg_height <= i_cfg_data[gls_pkg::CFG_HEIGHT_W-1:0];
                gls_pkg::CFG_INV:    r_cfg_inv    <= i_cfg_data[gls_pkg::CFG_INV_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Frame geometry and position of the incoming word
    // ---------------------------------------------------------------------
    logic [CW-1:0] w_ext, w_eff, lc, c_ext, c_cl;
    logic [RW-1:0] h_eff, lr;
    logic [AW-1:0] r_col, n_col, cur_col;
    logic [RW-1:0] r_row, n_row, cur_row;

    always_comb begin
        w_ext = CW'(r_cfg_width);
        if (w_ext < CW'(gls_pkg::MIN_DIM)) begin
            w_eff = CW'(gls_pkg::MIN_DIM);
        end else if (w_ext > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        lc = w_eff - CW'(1);
        h_eff = (r_cfg_height < RW'(gls_pkg::MIN_DIM)) ? RW'(gls_pkg::MIN_DIM) : r_cfg_height;
        lr = h_eff - RW'(1);
        // counters left beyond the frame by a register change snap to the edge
        c_ext   = CW'(r_col);
        c_cl    = (c_ext > lc) ? lc : c_ext;
        cur_col = c_cl[AW-1:0];
        cur_row = (r_row > lr) ? lr : r_row;
    end

    always_comb begin
        if (c_cl == lc) begin
            n_col = '0;
            n_row = (cur_row == lr) ? '0 : cur_row + RW'(1);
        end else begin
            n_col = cur_col + AW'(1);
            n_row = cur_row;
        end
    end

    gls_pkg::t_s1_ctl ctl;

    always_comb begin
        ctl.has_up   = (cur_row != '0);
        ctl.left_ok  = (cur_col != '0);
        ctl.right_ok = (c_cl != lc);
        ctl.up_ok    = (cur_row > RW'(1));
        ctl.last_row = (cur_row == lr);
        ctl.left2    = (c_cl > CW'(1));
        ctl.corner   = (c_cl == lc);
    end

    // ---------------------------------------------------------------------
    // Handshake of the read stage
    // ---------------------------------------------------------------------
    logic           in_acc, s1_adv, s2_can_load, s2_emit, out_free;
    logic           r_s1_vld;
    logic [2:0]     s1_mask;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign s1_adv     = r_s1_vld && ((s1_mask == 3'b000) || s2_can_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
                r_col    <= n_col;
                r_row    <= n_row;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    // previous two samples of the stream (row-crossing included, as the maths wants)
    logic signed [SW-1:0] r_prev, r_pprev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_pprev <= '0;
        end else if (in_acc) begin
            r_prev  <= i_sample;
            r_pprev <= r_prev;
        end
    end

    // ---------------------------------------------------------------------
    // Line stores: row above and row two above. Reads are issued on the
    // accept edge; the word in the read stage writes back when it leaves.
    // ---------------------------------------------------------------------
    logic signed [SW-1:0] r_row_above     [MAX_WIDTH];
    logic signed [SW-1:0] r_row_two_above [MAX_WIDTH];
    logic signed [SW-1:0] r_ra_q0, r_ra_q1, r_rt_q0, r_rt_qm;
    logic [AW-1:0]        addr_c, addr_r, addr_l;

    logic signed [SW-1:0] r_s1_s, r_s1_prev, r_s1_pprev;
    logic [AW-1:0]        r_s1_col;
    logic [RW-1:0]        r_s1_row;
    gls_pkg::t_s1_ctl     r_s1_ctl;
    gls_pkg::t_fwd        r_s1_fwd, fwd;
    logic signed [SW-1:0] r_fwd_s, r_fwd_a0;
    logic signed [SW-1:0] s1_a0, s1_a1, s1_t0, s1_tm;

    assign addr_c = cur_col;
    assign addr_r = ctl.right_ok ? cur_col + AW'(1) : cur_col;
    assign addr_l = ctl.left_ok ? cur_col - AW'(1) : cur_col;

    // the word leaving on this edge writes its column while we read
    always_comb begin
        fwd.ra_c = s1_adv && (addr_c == r_s1_col);
        fwd.ra_r = s1_adv && (addr_r == r_s1_col);
        fwd.rt_c = s1_adv && (addr_c == r_s1_col);
        fwd.rt_l = s1_adv && (addr_l == r_s1_col);
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_row_above[r_s1_col]     <= r_s1_s;
            r_row_two_above[r_s1_col] <= s1_a0;
        end
        if (in_acc) begin
            r_ra_q0 <= r_row_above[addr_c];
            r_ra_q1 <= r_row_above[addr_r];
            r_rt_q0 <= r_row_two_above[addr_c];
            r_rt_qm <= r_row_two_above[addr_l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_s     <= i_sample;
            r_s1_col   <= cur_col;
            r_s1_row   <= cur_row;
            r_s1_ctl   <= ctl;
            r_s1_prev  <= r_prev;
            r_s1_pprev <= r_pprev;
            r_s1_fwd   <= fwd;
            r_fwd_s    <= r_s1_s;
            r_fwd_a0   <= s1_a0;
        end
    end

    assign s1_a0 = r_s1_fwd.ra_c ? r_fwd_s  : r_ra_q0;   // centre
    assign s1_a1 = r_s1_fwd.ra_r ? r_fwd_s  : r_ra_q1;   // right
    assign s1_t0 = r_s1_fwd.rt_c ? r_fwd_a0 : r_rt_q0;   // up
    assign s1_tm = r_s1_fwd.rt_l ? r_fwd_a0 : r_rt_qm;   // left

    // ---------------------------------------------------------------------
    // Stencil sums
    //   sum0: point one row up, centre from the row above
    //   sum1: last row, point to the left of the sample
    //   sum2: last row, the sample itself on the last column
    // ---------------------------------------------------------------------
    function automatic logic signed [UW-1:0] times_n(input logic signed [UW-1:0] v,
                                                     input logic [2:0] n);
        logic signed [UW-1:0] res;
        case (n)
            3'd1:    res = v;
            3'd2:    res = v <<< 1;
            3'd3:    res = v + (v <<< 1);
            3'd4:    res = v <<< 2;
            default: res = '0;
        endcase
        return res;
    endfunction

    logic signed [UW-1:0] sum0, sum1, sum2;
    logic [2:0]           cnt0;

    always_comb begin
        logic signed [UW-1:0] e_s, e_a0, e_a1, e_t0, e_tm, e_p, e_pp;
        e_s  = UW'(r_s1_s);
        e_a0 = UW'(s1_a0);
        e_a1 = UW'(s1_a1);
        e_t0 = UW'(s1_t0);
        e_tm = UW'(s1_tm);
        e_p  = UW'(r_s1_prev);
        e_pp = UW'(r_s1_pprev);

        cnt0 = 3'd1 + {2'b00, r_s1_ctl.left_ok} + {2'b00, r_s1_ctl.right_ok}
             + {2'b00, r_s1_ctl.up_ok};
        sum0 = e_s + (r_s1_ctl.left_ok  ? e_tm : '0)
                   + (r_s1_ctl.right_ok ? e_a1 : '0)
                   + (r_s1_ctl.up_ok    ? e_t0 : '0)
                   - times_n(e_a0, cnt0);
        sum1 = e_s + e_tm + (r_s1_ctl.left2 ? e_pp : '0)
             - times_n(e_p, r_s1_ctl.left2 ? 3'd3 : 3'd2);
        sum2 = e_p + e_a0 - (e_s <<< 1);

        s1_mask = {r_s1_ctl.last_row && r_s1_ctl.corner,
                   r_s1_ctl.last_row && r_s1_ctl.left_ok,
                   r_s1_ctl.has_up};
    end

    // ---------------------------------------------------------------------
    // Pending results of one word, drained in point order, one per unstalled cycle
    // ---------------------------------------------------------------------
    logic [2:0]           r_s2_mask, s2_pick, s2_left;
    logic signed [UW-1:0] r_s2_sum0, r_s2_sum1, r_s2_sum2, s2_sum;
    logic [AW-1:0]        r_s2_col;
    logic [RW-1:0]        r_s2_row, s2_row;
    logic [CW-1:0]        s2_col;
    logic                 s2_eof;

    always_comb begin
        if (r_s2_mask[0]) begin
            s2_pick = 3'b001;
            s2_sum  = r_s2_sum0;
            s2_row  = r_s2_row - RW'(1);
            s2_col  = CW'(r_s2_col);
            s2_eof  = 1'b0;
        end else if (r_s2_mask[1]) begin
            s2_pick = 3'b010;
            s2_sum  = r_s2_sum1;
            s2_row  = r_s2_row;
            s2_col  = CW'(r_s2_col) - CW'(1);
            s2_eof  = 1'b0;
        end else begin
            s2_pick = 3'b100;
            s2_sum  = r_s2_sum2;
            s2_row  = r_s2_row;
            s2_col  = CW'(r_s2_col);
            s2_eof  = 1'b1;
        end
        s2_left = r_s2_mask & ~s2_pick;
    end

    assign out_free    = !o_out_valid || !i_out_stall;
    assign s2_emit     = (r_s2_mask != 3'b000) && out_free;
    assign s2_can_load = (r_s2_mask == 3'b000) || (s2_emit && (s2_left == 3'b000));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mask <= 3'b000;
        end else if (s1_adv && (s1_mask != 3'b000)) begin
            r_s2_mask <= s1_mask;
        end else if (s2_emit) begin
            r_s2_mask <= s2_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && (s1_mask != 3'b000)) begin
            r_s2_sum0 <= sum0;
            r_s2_sum1 <= sum1;
            r_s2_sum2 <= sum2;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
        end
    end

    // ---------------------------------------------------------------------
    // Scale by 1/dx^2 (Q16.16) into the output register; shift and clamp
    // after it. Arithmetic shift gives round toward minus infinity.
    // ---------------------------------------------------------------------
    logic signed [gls_pkg::PROD_W-1:0] prod, r_out_prod;
    logic signed [gls_pkg::Q_W-1:0]    q;
    logic signed [gls_pkg::CFG_INV_W:0] inv_s;
    logic                              r_out_vld, r_out_last, r_out_eof;
    logic [RW-1:0]                     r_out_row;
    logic [gls_pkg::COL_W-1:0]         r_out_col;

    assign inv_s = $signed({1'b0, r_cfg_inv});
    assign prod  = gls_pkg::PROD_W'(s2_sum) * gls_pkg::PROD_W'(inv_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_emit) begin
            r_out_vld <= 1'b1;
        end else if (out_free) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_emit) begin
            r_out_prod <= prod;
            r_out_row  <= s2_row;
            r_out_col  <= s2_col[gls_pkg::COL_W-1:0];
            r_out_last <= (s2_left == 3'b000);
            r_out_eof  <= s2_eof;
        end
    end

    always_comb begin
        q = r_out_prod[gls_pkg::PROD_W-1:gls_pkg::FRAC_W];
        if (q[gls_pkg::Q_W-1:gls_pkg::LAP_W-1] == '0
            || q[gls_pkg::Q_W-1:gls_pkg::LAP_W-1] == '1) begin
            o_laplacian = q[gls_pkg::LAP_W-1:0];
        end else if (q[gls_pkg::Q_W-1]) begin
            o_laplacian = gls_pkg::LAP_MIN;
        end else begin
            o_laplacian = gls_pkg::LAP_MAX;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_last_of_run)
        else $error("end of frame on a word that is not last of its run");

    a_s2_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && (s1_mask != 3'b000) |=> r_s2_mask == $past(s1_mask))
        else $error("pending results lost on hand-over from read stage");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> CW'(r_col) <= $past(lc))
        else $error("column counter beyond last column");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import gls_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 10;    // margin for words still in flight after the owed ones
    localparam int HOLD_CYCLES   = 200;   // long receiver hold-off to back the block up
    localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up
    localparam int RAND_WORDS    = 180;

    localparam logic signed [SAMPLE_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] Q_MIN = 16'sh8000;

    // one result word as the block should emit it
    typedef struct {
        logic signed [LAP_W-1:0] lap;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic                    last;
        logic                    eof;
    } lap_word_t;

    // Tracks the grid position and both line stores, and keeps the result
    // words still owed by the block in arrival order.
    class stencil_board;
        logic [CFG_WIDTH_W-1:0]     width_reg;
        logic [CFG_HEIGHT_W-1:0]    height_reg;
        logic [CFG_INV_W-1:0]       inv_reg;
        logic signed [SAMPLE_W-1:0] line_up [LINE_DEPTH];
        logic signed [SAMPLE_W-1:0] line_up2 [LINE_DEPTH];
        int                         prev_s;
        int                         prev2_s;
        int                         col_n;
        int                         row_n;
        int                         errors;
        lap_word_t                  due_words[$];

        function new();
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            inv_reg    = INV_RST;
            foreach (line_up[k]) begin
                line_up[k]  = '0;
                line_up2[k] = '0;
            end
            prev_s  = 0;
            prev2_s = 0;
            col_n   = 0;
            row_n   = 0;
            errors  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_WIDTH:  width_reg  = v[CFG_WIDTH_W-1:0];
                CFG_HEIGHT: height_reg = v[CFG_HEIGHT_W-1:0];
                CFG_INV:    inv_reg    = v[CFG_INV_W-1:0];
                default: ;
            endcase
        endfunction

        // scale by the Q16.16 gain, floor the shift, clip to 32 bits
        function lap_word_t scaled_word(int sum, int r, int c, logic eof);
            lap_word_t wd;
            longint    p;
            p = longint'(sum) * longint'({32'd0, inv_reg});
            p = p >>> FRAC_W;
            if (p > longint'(LAP_MAX)) p = longint'(LAP_MAX);
            if (p < longint'(LAP_MIN)) p = longint'(LAP_MIN);
            wd.lap  = p[LAP_W-1:0];
            wd.row  = r[ROW_W-1:0];
            wd.col  = c[COL_W-1:0];
            wd.last = 1'b0;
            wd.eof  = eof;
            return wd;
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] smp);
            lap_word_t run [3];
            int        w;
            int        h;
            int        r;
            int        c;
            int        s;
            int        sum;
            int        cnt;
            int        n;
            w = width_reg;
            h = height_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > LINE_DEPTH) w = LINE_DEPTH;
            if (h < MIN_DIM) h = MIN_DIM;
            // a register change may leave the counters past the frame
            if (col_n > w - 1) col_n = w - 1;
            if (row_n > h - 1) row_n = h - 1;
            r = row_n;
            c = col_n;
            s = smp;
            n = 0;

            // point one row up: its centre sits in line_up
            if (r >= 1) begin
                sum = s;
                cnt = 1;
                if (c > 0) begin
                    sum += line_up2[c-1];
                    cnt++;
                end
                if (c < w - 1) begin
                    sum += line_up[c+1];
                    cnt++;
                end
                if (r > 1) begin
                    sum += line_up2[c];
                    cnt++;
                end
                sum -= cnt * line_up[c];
                run[n] = scaled_word(sum, r - 1, c, 1'b0);
                n++;
            end
            line_up2[c] = line_up[c];
            line_up[c]  = smp;

            // last row has no row below, so its points close out here
            if (r == h - 1) begin
                if (c >= 1) begin
                    sum = s + line_up2[c-1];
                    cnt = 2;
                    if (c > 1) begin
                        sum += prev2_s;
                        cnt++;
                    end
                    sum -= cnt * prev_s;
                    run[n] = scaled_word(sum, r, c - 1, 1'b0);
                    n++;
                end
                if (c == w - 1) begin
                    sum = prev_s + line_up2[c] - 2 * s;
                    run[n] = scaled_word(sum, r, c, 1'b1);
                    n++;
                end
            end
            for (int k = 0; k < n; k++) begin
                if (k == n - 1) run[k].last = 1'b1;
                due_words.push_back(run[k]);
            end

            prev2_s = prev_s;
            prev_s  = s;
            if (c >= w - 1) begin
                col_n = 0;
                row_n = (r >= h - 1) ? 0 : r + 1;
            end else begin
                col_n = c + 1;
            end
        endfunction

        function void check_word(lap_word_t got);
            lap_word_t want;
            if (due_words.size() == 0) begin
                $error("unexpected result word at row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            want = due_words.pop_front();
            if (got.lap !== want.lap) begin
                $error("laplacian: expected %0d, got %0d", want.lap, got.lap);
                errors++;
            end
            if (got.row !== want.row) begin
                $error("out_row: expected %0d, got %0d", want.row, got.row);
                errors++;
            end
            if (got.col !== want.col) begin
                $error("out_col: expected %0d, got %0d", want.col, got.col);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_run: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.eof !== want.eof) begin
                $error("end_of_frame: expected %0d, got %0d", want.eof, got.eof);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [LAP_W-1:0]    o_laplacian;
    logic [ROW_W-1:0]           o_out_row;
    logic [COL_W-1:0]           o_out_col;
    logic                       o_last_of_run;
    logic                       o_end_of_frame;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = CFG_WIDTH;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    stencil_board board;
    int           words_sent = 0;
    int           in_idle_pct = 0;
    int           out_idle_pct = 0;
    int           hold_asked = 0;
    int           hold_done = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;

    grid_laplacian_stencil DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_laplacian    (o_laplacian),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Both channels are sampled at the edge, before any of this edge's
    // nonblocking updates land, so every process sees pre-edge values.
    always @(posedge i_clk) begin : watch_ports
        lap_word_t seen;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.take_sample(i_sample);
            if (o_out_valid && !i_out_stall) begin
                seen.lap  = o_laplacian;
                seen.row  = o_out_row;
                seen.col  = o_out_col;
                seen.last = o_last_of_run;
                seen.eof  = o_end_of_frame;
                board.check_word(seen);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever the stimulus
    // asks for one, so the pipeline fills and the input side stalls too.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_done != hold_asked) begin
            hold_done   <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
            || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(int ext_pct);
        logic [31:0] raw;
        if ($urandom_range(99) < ext_pct) begin
            case ($urandom_range(3))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        raw = $urandom;
        return raw[SAMPLE_W-1:0];
    endfunction

    // Offer one sample word; returns on the edge that accepts it with valid
    // still high, so valid drops between words only when the sender idles.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // Drop valid, wait for every owed word, then let the pipeline drain
    // any row-0 word that owes nothing but may still be in flight.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_reg(idx, v);
    endtask

    task automatic load_grid(input int w, input int h, input logic [CFG_INV_W-1:0] inv);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_INV, inv);
        i_cfg_we <= 1'b0;
    endtask

    // Program the grid and send n words (a whole frame when n is 0); the
    // chequer option alternates full-scale words to hit both rails.
    task automatic run_frame(input int w, input int h, input logic [CFG_INV_W-1:0] inv,
                             input int ext_pct, input int n, input bit chequer);
        int ew;
        int eh;
        int total;
        ew = (w < MIN_DIM) ? MIN_DIM : ((w > LINE_DEPTH) ? LINE_DEPTH : w);
        eh = (h < MIN_DIM) ? MIN_DIM : h;
        total = (n > 0) ? n : ew * eh;
        load_grid(w, h, inv);
        for (int k = 0; k < total; k++) begin
            if (chequer) push_sample(((k / ew + k % ew) % 2) ? Q_MAX : Q_MIN);
            else push_sample(pick_sample(ext_pct));
        end
        settle_block();
    endtask

    initial begin : stimulus
        int          rand_start;
        int          phase;
        int          w;
        int          h;
        bit          pressed;
        logic [31:0] inv;
        board   = new();
        pressed = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: sender idles now and then, receiver mostly stalls
        in_idle_pct   = 30;
        out_idle_pct <= 79;
        // smallest grid, all corners, full-scale words
        run_frame(2, 2, INV_RST, 100, 0, 0);
        // extents below range act as two; largest gain saturates
        run_frame(0, 0, 32'hFFFF_FFFF, 100, 0, 0);
        run_frame(1, 1, 32'd0, 100, 0, 0);
        // chequerboard: interior to the top rail, edges to the bottom rail
        run_frame(3, 3, 32'hFFFF_FFFF, 0, 0, 1);
        // odd gain exercises the floor on negative products
        run_frame(3, 3, 32'h0000_8001, 50, 0, 0);
        // width cut mid-row: column count pulled back to the last column
        run_frame(8, 4, $urandom, 20, 21, 0);
        run_frame(4, 4, $urandom, 20, 5, 0);
        // width above range acts as a full line store; then cut during row 0
        run_frame(2047, 65535, INV_RST, 20, 10, 0);
        run_frame(10, 3, INV_RST, 20, 21, 0);
        run_frame(1024, 2, INV_RST, 20, 3, 0);
        run_frame(2, 2, INV_RST, 20, 3, 0);
        // tallest grid cut short: row count pulled back to the last row
        run_frame(3, 65535, $urandom, 20, 13, 0);
        run_frame(3, 3, $urandom, 20, 2, 0);

        // random frames, mostly small, in three idling regimes
        rand_start = words_sent;
        while (words_sent - rand_start < RAND_WORDS) begin
            phase = (words_sent - rand_start) * 3 / RAND_WORDS;
            case (phase)
                0: begin
                    in_idle_pct   = 30;
                    out_idle_pct <= 79;
                end
                1: begin
                    in_idle_pct   = 79;
                    out_idle_pct <= 30;
                end
                default: begin
                    in_idle_pct   = 0;
                    out_idle_pct <= 0;
                end
            endcase
            case ($urandom_range(19))
                0:       w = $urandom_range(1);
                1, 2:    w = $urandom_range(40, 13);
                default: w = $urandom_range(12, 2);
            endcase
            case ($urandom_range(19))
                0:       h = $urandom_range(1);
                1:       h = $urandom_range(12, 7);
                default: h = $urandom_range(6, 2);
            endcase
            case ($urandom_range(3))
                0:       inv = INV_RST;
                1:       inv = $urandom;
                2:       inv = $urandom_range(32'h0003_0000);
                default: inv = 32'hFFFF_FFFF;
            endcase
            // one frame under a long hold-off while words keep coming
            if (phase == 2 && !pressed) begin
                pressed     = 1'b1;
                hold_asked <= hold_asked + 1;
                w = 8;
                h = 6;
            end
            run_frame(w, h, inv, 10, 0, 0);
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.due_words.size() != 0) begin
            $error("%0d expected words never arrived", board.due_words.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
